/* hdl/circular_indexed_deque_defines.svh */
// Assertion macros shared by the deque RTL.
// Each macro expects i_clk and i_rst_n in scope and is quiet while reset is held.
`ifndef CIRCULAR_INDEXED_DEQUE_DEFINES_SVH
`define CIRCULAR_INDEXED_DEQUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CID_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cid_pkg.sv */
`default_nettype none

package cid_pkg;

    // Storage geometry and field widths.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;
    localparam int SUM_W    = POS_W + 1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_SET    = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GET_WAIT,
        S_SHIFT,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Request word.
    typedef struct packed {
        t_op                      operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [POS_W-1:0]         count;
        t_status                  status;
    } t_rsp;

    // Memory access bundle from the sequencer to the ring store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Physical slot of a logical index, wrapping once around the ring.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [POS_W-1:0] idx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(idx);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/cid_ram.sv */
`default_nettype none

// Ring store: one write port and one read port with registered read data.
module cid_ram (
    input  wire logic                       i_clk,
    input  wire cid_pkg::t_ram_req          i_ram_req,
    output logic [cid_pkg::DATA_W-1:0]      o_rdata
);

    logic [cid_pkg::DATA_W-1:0] r_mem [cid_pkg::CAPACITY];
    logic [cid_pkg::DATA_W-1:0] r_rdata;

    // Write and read happen on the same edge; the shift loop never reads a slot
    // in the cycle it writes it.
    always_ff @(posedge i_clk) begin
        if (i_ram_req.we) begin
            r_mem[i_ram_req.waddr] <= i_ram_req.wdata;
        end
        r_rdata <= r_mem[i_ram_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/cid_seq.sv */
`default_nettype none

// Request sequencer: holds head and count, decodes each request and walks the
// shift loop one element per cycle through the ring store.
module cid_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire cid_pkg::t_req              i_req,
    input  wire logic [cid_pkg::DATA_W-1:0] i_rdata,
    output logic                            o_busy,
    output cid_pkg::t_ram_req               o_ram_req,
    output logic                            o_strobe,
    output cid_pkg::t_rsp                   o_rsp
);

    cid_pkg::t_state                 r_state,   n_state;
    logic [cid_pkg::ADDR_W-1:0]      r_head,    n_head;
    logic [cid_pkg::POS_W-1:0]       r_count,   n_count;
    cid_pkg::t_req                   r_req,     n_req;
    logic [cid_pkg::POS_W-1:0]       r_k,       n_k;
    logic                            r_wr_pend, n_wr_pend;
    logic [cid_pkg::ADDR_W-1:0]      r_wr_slot, n_wr_slot;
    logic                            r_strobe,  n_strobe;
    cid_pkg::t_rsp                   r_rsp,     n_rsp;

    logic                            w_is_ins;
    logic [cid_pkg::POS_W-1:0]       w_pos;
    logic [cid_pkg::POS_W-1:0]       w_last_idx;
    cid_pkg::t_status                w_status;
    logic                            w_ins_mid;
    logic                            w_ers_mid;
    logic                            w_shift_last;
    logic [cid_pkg::POS_W-1:0]       w_src_k;
    logic [cid_pkg::ADDR_W-1:0]      w_pos_slot;
    logic [cid_pkg::ADDR_W-1:0]      w_cnt_slot;
    logic [cid_pkg::ADDR_W-1:0]      w_src_slot;
    logic [cid_pkg::ADDR_W-1:0]      w_dst_slot;
    logic [cid_pkg::ADDR_W-1:0]      w_head_dec;
    logic [cid_pkg::ADDR_W-1:0]      w_head_inc;

    // Decode of the held request.
    always_comb begin
        w_is_ins   = (r_req.operation == cid_pkg::OP_INSERT);
        w_pos      = r_req.position;
        w_last_idx = r_count - cid_pkg::POS_W'(1);
        if (w_is_ins) begin
            if (w_pos > r_count) begin
                w_status = cid_pkg::ST_RANGE;
            end else if (r_count == cid_pkg::POS_W'(cid_pkg::CAPACITY)) begin
                w_status = cid_pkg::ST_FULL;
            end else begin
                w_status = cid_pkg::ST_OK;
            end
        end else if (w_pos >= r_count) begin
            w_status = cid_pkg::ST_RANGE;
        end else begin
            w_status = cid_pkg::ST_OK;
        end
        w_ins_mid    = (w_pos != '0) && (w_pos != r_count);
        w_ers_mid    = (w_pos != '0) && (w_pos != w_last_idx);
        // Insert moves data toward the back, erase toward the front.
        w_src_k      = w_is_ins ? (r_k - cid_pkg::POS_W'(1)) : (r_k + cid_pkg::POS_W'(1));
        w_shift_last = w_is_ins ? (r_k == w_pos + cid_pkg::POS_W'(1))
                                : (r_k + cid_pkg::POS_W'(2) == r_count);
    end

    // Slot addresses and head neighbors.
    always_comb begin
        w_pos_slot = cid_pkg::slot_of(r_head, w_pos);
        w_cnt_slot = cid_pkg::slot_of(r_head, r_count);
        w_src_slot = cid_pkg::slot_of(r_head, w_src_k);
        w_dst_slot = cid_pkg::slot_of(r_head, r_k);
        w_head_dec = (r_head == '0) ? cid_pkg::ADDR_W'(cid_pkg::CAPACITY - 1)
                                    : r_head - cid_pkg::ADDR_W'(1);
        w_head_inc = (r_head == cid_pkg::ADDR_W'(cid_pkg::CAPACITY - 1)) ? '0
                                    : r_head + cid_pkg::ADDR_W'(1);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cid_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = cid_pkg::S_DECODE;
                end
            end
            cid_pkg::S_DECODE: begin
                n_state = cid_pkg::S_IDLE;
                if (w_status == cid_pkg::ST_OK) begin
                    case (r_req.operation)
                        cid_pkg::OP_GET: begin
                            n_state = cid_pkg::S_GET_WAIT;
                        end
                        cid_pkg::OP_INSERT: begin
                            if (w_ins_mid) begin
                                n_state = cid_pkg::S_SHIFT;
                            end
                        end
                        cid_pkg::OP_ERASE: begin
                            if (w_ers_mid) begin
                                n_state = cid_pkg::S_SHIFT;
                            end
                        end
                        default: begin
                            n_state = cid_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            cid_pkg::S_GET_WAIT: begin
                n_state = cid_pkg::S_IDLE;
            end
            cid_pkg::S_SHIFT: begin
                if (w_shift_last) begin
                    n_state = cid_pkg::S_DRAIN;
                end
            end
            cid_pkg::S_DRAIN: begin
                n_state = cid_pkg::S_FINISH;
            end
            cid_pkg::S_FINISH: begin
                n_state = cid_pkg::S_IDLE;
            end
            default: begin
                n_state = cid_pkg::S_IDLE;
            end
        endcase
    end

    // Memory controls and register updates.
    always_comb begin
        n_head          = r_head;
        n_count         = r_count;
        n_req           = r_req;
        n_k             = r_k;
        n_wr_pend       = r_wr_pend;
        n_wr_slot       = r_wr_slot;
        n_strobe        = 1'b0;
        n_rsp           = r_rsp;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_wr_slot;
        o_ram_req.wdata = i_rdata;
        o_ram_req.raddr = w_src_slot;
        case (r_state)
            cid_pkg::S_IDLE: begin
                n_wr_pend = 1'b0;
                if (i_start) begin
                    n_req = i_req;
                end
            end
            cid_pkg::S_DECODE: begin
                n_rsp.read_data = '0;
                n_rsp.status    = w_status;
                n_strobe        = 1'b1;
                if (w_status == cid_pkg::ST_OK) begin
                    case (r_req.operation)
                        cid_pkg::OP_INSERT: begin
                            if (w_pos == '0) begin
                                n_head          = w_head_dec;
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = w_head_dec;
                                o_ram_req.wdata = r_req.value;
                                n_count         = r_count + cid_pkg::POS_W'(1);
                            end else if (w_pos == r_count) begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = w_cnt_slot;
                                o_ram_req.wdata = r_req.value;
                                n_count         = r_count + cid_pkg::POS_W'(1);
                            end else begin
                                n_k      = r_count;
                                n_strobe = 1'b0;
                            end
                        end
                        cid_pkg::OP_ERASE: begin
                            if (w_pos == '0) begin
                                n_head  = w_head_inc;
                                n_count = w_last_idx;
                            end else if (w_pos == w_last_idx) begin
                                n_count = w_last_idx;
                            end else begin
                                n_k      = w_pos;
                                n_strobe = 1'b0;
                            end
                        end
                        cid_pkg::OP_SET: begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = w_pos_slot;
                            o_ram_req.wdata = r_req.value;
                        end
                        cid_pkg::OP_GET: begin
                            o_ram_req.raddr = w_pos_slot;
                            n_strobe        = 1'b0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
                n_rsp.count = n_count;
            end
            cid_pkg::S_GET_WAIT: begin
                n_rsp.read_data = i_rdata;
                n_rsp.count     = r_count;
                n_rsp.status    = cid_pkg::ST_OK;
                n_strobe        = 1'b1;
            end
            cid_pkg::S_SHIFT: begin
                // Read the next source while writing the word read last cycle.
                o_ram_req.we = r_wr_pend;
                n_wr_slot    = w_dst_slot;
                n_wr_pend    = 1'b1;
                n_k          = w_src_k;
            end
            cid_pkg::S_DRAIN: begin
                o_ram_req.we = r_wr_pend;
                n_wr_pend    = 1'b0;
            end
            cid_pkg::S_FINISH: begin
                if (w_is_ins) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = w_pos_slot;
                    o_ram_req.wdata = r_req.value;
                    n_count         = r_count + cid_pkg::POS_W'(1);
                end else begin
                    n_count = w_last_idx;
                end
                n_rsp.read_data = '0;
                n_rsp.count     = n_count;
                n_rsp.status    = cid_pkg::ST_OK;
                n_strobe        = 1'b1;
            end
            default: begin
                n_wr_pend = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cid_pkg::S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_wr_pend <= n_wr_pend;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_k       <= n_k;
        r_wr_slot <= n_wr_slot;
        r_rsp     <= n_rsp;
    end

    assign o_busy   = (r_state != cid_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

`default_nettype wire

/* hdl/circular_indexed_deque.sv */
// Set, front or back insert and erase, and refused requests strobe their result from the
// decode state; get strobes after the get-wait state captures the registered read data;
// a middle insert or erase strobes after the shift loop and the drain and finish states.
// The shift moves one word per cycle through the single read and write port of the store.
// A new word is taken on the cycle the previous result is strobed; the receiver cannot stall.
// Synchronous reset clears head and count; store contents stay undefined until written.
`default_nettype none

`include "circular_indexed_deque_defines.svh"

module circular_indexed_deque (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire cid_pkg::t_req i_req,
    output logic               busy,
    output logic               o_strobe,
    output cid_pkg::t_rsp      o_rsp
);

    cid_pkg::t_ram_req          w_ram_req;
    logic [cid_pkg::DATA_W-1:0] w_rdata;

    // Sequencer owning head, count and the shift loop.
    cid_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_rdata   (w_rdata),
        .o_busy    (busy),
        .o_ram_req (w_ram_req),
        .o_strobe  (o_strobe),
        .o_rsp     (o_rsp)
    );

    // Element storage.
    cid_ram u_ram (
        .i_clk     (i_clk),
        .i_ram_req (w_ram_req),
        .o_rdata   (w_rdata)
    );

    // Checks on the sequencing and the result word.
    `CID_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `CID_ASSERT_NEXT(a_single_strobe, o_strobe, !o_strobe, "result strobed twice in a row")
    `CID_ASSERT_SAME(a_count_bound, o_strobe, o_rsp.count <= cid_pkg::CAPACITY, "count exceeds capacity")
    `CID_ASSERT_SAME(a_refused_zero, o_strobe && o_rsp.status != cid_pkg::ST_OK, o_rsp.read_data == '0, "refused request returned data")
    `CID_ASSERT_SAME(a_full_count, o_strobe && o_rsp.status == cid_pkg::ST_FULL, o_rsp.count == cid_pkg::CAPACITY, "full status with spare room")

endmodule

`default_nettype wire
